// File: rtl/core/gvtn_pkg.sv
package gvtn_pkg;

  // Sizes
  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int TIME_W    = 48;
  localparam int HALF_W    = TIME_W / 2;
  localparam int MULT_W    = 16;
  localparam int FRAC_W    = 8;
  localparam int PROD_W    = MULT_W + TIME_W;
  localparam int PART_W    = MULT_W + HALF_W;
  localparam int INC_W     = PROD_W - FRAC_W;
  localparam int SUM_W     = INC_W + 1;
  localparam int CFG_W     = 16;
  localparam int IDX_W     = 2;
  localparam int TOPO_W    = NODE_W + 4;

  // Group queue
  localparam int GQ_DEPTH  = 8;
  localparam int GQ_AW     = $clog2(GQ_DEPTH);
  localparam int GQ_CW     = GQ_AW + 1;

  localparam logic [TIME_W-1:0] T_ONES = '1;
  localparam logic [TIME_W-1:0] T_INF  = T_ONES - TIME_W'(1);

  // Operation codes
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_REPORT = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  // Message types
  localparam logic [1:0] MT_START  = 2'd0;
  localparam logic [1:0] MT_REPORT = 2'd1;
  localparam logic [1:0] MT_UPDATE = 2'd2;

  // Result kinds
  localparam logic KIND_MSG    = 1'b0;
  localparam logic KIND_COMMIT = 1'b1;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_NODE_ID     = 2'd0;
  localparam logic [IDX_W-1:0] REG_NODE_COUNT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW_MULT = 2'd2;

  // Links of this node in both trees
  typedef struct packed {
    logic [1:0]        nfrom;
    logic [NODE_W-1:0] from0;
    logic [NODE_W-1:0] from1;
    logic [1:0]        nto;
    logic [NODE_W-1:0] to0;
    logic [NODE_W-1:0] to1;
    logic [1:0]        nupd;
    logic [NODE_W-1:0] out0;
    logic [NODE_W-1:0] out1;
  } topo_t;

  // All results caused by one item
  typedef struct packed {
    logic [1:0]        nsend;
    logic              commit;
    logic [1:0]        mtype;
    logic [NODE_W-1:0] dest0;
    logic [NODE_W-1:0] dest1;
    logic [TIME_W-1:0] tval;
    logic [TIME_W-1:0] window;
  } grp_t;

  // Commit operands for the window pipeline
  typedef struct packed {
    logic              incr;
    logic [TIME_W-1:0] gold;
    logic [TIME_W-1:0] diff;
  } cmt_t;

endpackage

// File: rtl/core/gvtn_topo.sv
module gvtn_topo import gvtn_pkg::*; (
  input  logic              clk,
  input  logic [NODE_W-1:0] node_id,
  input  logic [CNT_W-1:0]  node_count,
  output topo_t             topo
);

  topo_t topo_r;
  topo_t topo_nxt;

  logic [CNT_W-1:0]         n_cl;
  logic signed [TOPO_W-1:0] sn, sme, mid0, mid1, inv, out0, out1, ofrom;
  logic signed [TOPO_W-1:0] in0, in1, into, pw, p0, p1;

  always_comb begin
    // zero acts as one, above the maximum acts as the maximum
    if (node_count == '0) begin
      n_cl = CNT_W'(1);
    end else if (node_count > CNT_W'(MAX_NODES)) begin
      n_cl = CNT_W'(MAX_NODES);
    end else begin
      n_cl = node_count;
    end
    sn    = TOPO_W'(signed'({1'b0, n_cl}));
    sme   = TOPO_W'(signed'({1'b0, node_id}));
    mid0  = (sn - TOPO_W'(1)) >>> 1;
    mid1  = sn[0] ? mid0 : mid0 + TOPO_W'(1);
    inv   = sn - sme - TOPO_W'(1);
    out0  = (sme <<< 1) + TOPO_W'(1);
    out1  = out0 + TOPO_W'(1);
    ofrom = (sme > 0) ? ((sme - TOPO_W'(1)) >>> 1) : '0;
    in0   = (sme <<< 1) - sn;
    in1   = in0 - TOPO_W'(1);
    into  = (sn + sme + TOPO_W'(1)) >>> 1;

    // smallest 2^k-1 not below mid0+1
    pw = TOPO_W'(1);
    for (int k = 1; k <= NODE_W; k++) begin
      if (((TOPO_W'(1) <<< k) - TOPO_W'(1)) < mid0 + TOPO_W'(1)) begin
        pw = (TOPO_W'(1) <<< (k + 1)) - TOPO_W'(1);
      end
    end
    p0 = (pw >>> 1) - TOPO_W'(1);
    p1 = sn - p0 - TOPO_W'(1);
    if (p1 <= (p0 <<< 1) + TOPO_W'(3)) begin
      mid0 = p1 - TOPO_W'(1);
      mid1 = p0 + TOPO_W'(1);
    end

    topo_nxt = '0;
    if (sme == 0) begin
      topo_nxt.nfrom = 2'd0;
    end else if (sme <= mid0) begin
      topo_nxt.nfrom = 2'd1;
      topo_nxt.from0 = ofrom[NODE_W-1:0];
    end else if (mid1 <= in1) begin
      topo_nxt.nfrom = 2'd2;
      topo_nxt.from0 = in0[NODE_W-1:0];
      topo_nxt.from1 = in1[NODE_W-1:0];
    end else if (mid1 == in0) begin
      topo_nxt.nfrom = 2'd1;
      topo_nxt.from0 = in0[NODE_W-1:0];
    end else begin
      topo_nxt.nfrom = 2'd1;
      topo_nxt.from0 = inv[NODE_W-1:0];
    end

    if (sme == sn - TOPO_W'(1)) begin
      topo_nxt.nto = 2'd0;
    end else if (sme >= mid1) begin
      topo_nxt.nto = 2'd1;
      topo_nxt.to0 = into[NODE_W-1:0];
    end else if (mid0 >= out1) begin
      topo_nxt.nto = 2'd2;
      topo_nxt.to0 = out0[NODE_W-1:0];
      topo_nxt.to1 = out1[NODE_W-1:0];
    end else if (mid0 == out0) begin
      topo_nxt.nto = 2'd1;
      topo_nxt.to0 = out0[NODE_W-1:0];
    end else begin
      topo_nxt.nto = 2'd1;
      topo_nxt.to0 = inv[NODE_W-1:0];
    end

    // tree A children that exist
    if (out1 < sn) begin
      topo_nxt.nupd = 2'd2;
    end else if (out0 < sn) begin
      topo_nxt.nupd = 2'd1;
    end else begin
      topo_nxt.nupd = 2'd0;
    end
    topo_nxt.out0 = out0[NODE_W-1:0];
    topo_nxt.out1 = out1[NODE_W-1:0];
  end

  always_ff @(posedge clk) begin
    topo_r <= topo_nxt;
  end

  assign topo = topo_r;

endmodule

// File: rtl/core/gvtn_ctrl.sv
module gvtn_ctrl import gvtn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [1:0]        op,
  input  logic [TIME_W-1:0] msg_time,
  input  logic [TIME_W-1:0] local_lvt,
  input  topo_t             topo,
  output logic              s2_valid,
  output grp_t              s2_grp,
  output cmt_t              s2_cmt
);

  // input register
  logic              v1_r;
  logic [1:0]        op_r;
  logic [TIME_W-1:0] mt_r, lvt_r;

  // node state
  logic [TIME_W-1:0] gt_r, gt_nxt;
  logic [TIME_W-1:0] rm_r, rm_nxt;
  logic              a1_r, a1_nxt;

  // stage 2 register
  logic              v2_r;
  grp_t              grp2_r, grp_nxt;
  cmt_t              cmt2_r, cmt_nxt;

  logic              a1s, do_rep, do_upd;
  logic [TIME_W-1:0] rep_lvt, upd_v, rm1, rm2;

  always_comb begin
    gt_nxt  = gt_r;
    rm_nxt  = rm_r;
    a1_nxt  = a1_r;
    a1s     = a1_r;
    do_rep  = 1'b0;
    do_upd  = 1'b0;
    rep_lvt = mt_r;
    upd_v   = mt_r;
    rm1     = '0;
    rm2     = '0;
    grp_nxt = '0;
    cmt_nxt = '0;

    case (op_r)
      OP_START: begin
        // a node with two senders waits for both starts
        if (topo.nfrom == 2'd2 && !a1_r) begin
          a1_nxt = 1'b1;
        end else begin
          if (topo.nfrom == 2'd2) begin
            a1s    = 1'b0;
            a1_nxt = 1'b0;
          end
          if (topo.nto != 2'd0) begin
            grp_nxt.nsend = topo.nto;
            grp_nxt.mtype = MT_START;
            grp_nxt.dest0 = topo.to0;
            grp_nxt.dest1 = topo.to1;
            grp_nxt.tval  = gt_r;
          end else begin
            do_rep  = 1'b1;
            rep_lvt = rm_r;
          end
        end
      end
      OP_REPORT: begin
        do_rep  = 1'b1;
        rep_lvt = mt_r;
      end
      OP_UPDATE: begin
        do_upd = 1'b1;
        upd_v  = mt_r;
      end
      default: begin
      end
    endcase

    if (do_rep) begin
      rm1    = a1s ? rm_r : lvt_r;
      rm2    = (rep_lvt < rm1) ? rep_lvt : rm1;
      rm_nxt = rm2;
      if (topo.nto == 2'd2 && !a1s) begin
        a1_nxt = 1'b1;
      end else begin
        a1_nxt = (topo.nto == 2'd2) ? 1'b0 : a1s;
        if (topo.nfrom != 2'd0) begin
          grp_nxt.nsend = topo.nfrom;
          grp_nxt.mtype = MT_REPORT;
          grp_nxt.dest0 = topo.from0;
          grp_nxt.dest1 = topo.from1;
          grp_nxt.tval  = rm2;
        end else begin
          do_upd = 1'b1;
          upd_v  = rm2;
        end
      end
    end

    if (do_upd) begin
      grp_nxt.nsend  = topo.nupd;
      grp_nxt.commit = 1'b1;
      grp_nxt.mtype  = MT_UPDATE;
      grp_nxt.dest0  = topo.out0;
      grp_nxt.dest1  = topo.out1;
      grp_nxt.tval   = upd_v;
      cmt_nxt.incr   = upd_v > gt_r;
      cmt_nxt.gold   = gt_r;
      cmt_nxt.diff   = upd_v - gt_r;
      rm_nxt         = T_ONES;
      gt_nxt         = upd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      gt_r <= '0;
      rm_r <= T_ONES;
      a1_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      if (v1_r) begin
        gt_r <= gt_nxt;
        rm_r <= rm_nxt;
        a1_r <= a1_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r  <= op;
      mt_r  <= msg_time;
      lvt_r <= local_lvt;
    end
    grp2_r <= grp_nxt;
    cmt2_r <= cmt_nxt;
  end

  assign s2_valid = v2_r;
  assign s2_grp   = grp2_r;
  assign s2_cmt   = cmt2_r;

endmodule

// File: rtl/core/gvtn_window.sv
module gvtn_window import gvtn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s2_valid,
  input  grp_t              s2_grp,
  input  cmt_t              s2_cmt,
  input  logic [MULT_W-1:0] window_mult,
  output logic              done,
  output logic              push,
  output grp_t              push_grp
);

  // stage 3: two partial products
  logic              v3_r;
  grp_t              grp3_r;
  logic              incr3_r;
  logic [TIME_W-1:0] gold3_r;
  logic [PART_W-1:0] plo3_r, phi3_r;

  // stage 4: whole product
  logic              v4_r;
  grp_t              grp4_r;
  logic              incr4_r;
  logic [TIME_W-1:0] gold4_r;
  logic [PROD_W-1:0] prod4_r;

  logic [TIME_W-1:0] wb_r;

  logic [PART_W-1:0] plo_nxt, phi_nxt;
  logic [PROD_W-1:0] prod_nxt;
  logic [SUM_W-1:0]  sum;
  logic              sat;
  logic [TIME_W-1:0] win;

  assign plo_nxt  = PART_W'(window_mult) * PART_W'(s2_cmt.diff[HALF_W-1:0]);
  assign phi_nxt  = PART_W'(window_mult) * PART_W'(s2_cmt.diff[TIME_W-1:HALF_W]);
  assign prod_nxt = {phi3_r, {HALF_W{1'b0}}} + PROD_W'(plo3_r);

  // old value plus the scaled increase, saturated at infinity; a non-increasing commit keeps the previous bound
  assign sum = SUM_W'(gold4_r) + SUM_W'(prod4_r[PROD_W-1:FRAC_W]);
  assign sat = sum > SUM_W'(T_INF);
  assign win = !incr4_r ? wb_r : (sat ? T_INF : sum[TIME_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      wb_r <= T_INF;
    end else begin
      v3_r <= s2_valid;
      v4_r <= v3_r;
      if (v4_r && grp4_r.commit) begin
        wb_r <= win;
      end
    end
  end

  always_ff @(posedge clk) begin
    grp3_r  <= s2_grp;
    incr3_r <= s2_cmt.incr;
    gold3_r <= s2_cmt.gold;
    plo3_r  <= plo_nxt;
    phi3_r  <= phi_nxt;
    grp4_r  <= grp3_r;
    incr4_r <= incr3_r;
    gold4_r <= gold3_r;
    prod4_r <= prod_nxt;
  end

  always_comb begin
    push_grp        = grp4_r;
    push_grp.window = grp4_r.commit ? win : '0;
  end

  assign done = v4_r;
  assign push = v4_r && (grp4_r.nsend != 2'd0 || grp4_r.commit);

endmodule

// File: rtl/core/gvtn_outq.sv
module gvtn_outq import gvtn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  grp_t              push_grp,
  output logic [GQ_CW-1:0]  count,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [103:0]      out_tdata,
  output logic [0:0]        out_tuser,
  output logic              out_tlast
);

  grp_t              mem [GQ_DEPTH];
  logic [GQ_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [GQ_CW-1:0]  cnt_r;
  logic [1:0]        idx_r;

  logic              ov_r;
  logic              kind_r, last_r;
  logic [NODE_W-1:0] dest_r;
  logic [1:0]        mtype_r;
  logic [TIME_W-1:0] tval_r, win_r;

  grp_t              head;
  logic [1:0]        total;
  logic              is_send, last_res, load, pop;

  assign head     = mem[rd_ptr_r];
  assign total    = head.nsend + {1'b0, head.commit};
  assign is_send  = idx_r < head.nsend;
  assign last_res = idx_r == total - 2'd1;
  assign load     = (cnt_r != '0) && (!ov_r || out_tready);
  assign pop      = load && last_res;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      idx_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + GQ_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + GQ_AW'(1);
      end
      cnt_r <= cnt_r + GQ_CW'(push) - GQ_CW'(pop);
      if (load) begin
        idx_r <= last_res ? 2'd0 : idx_r + 2'd1;
        ov_r  <= 1'b1;
      end else if (out_tready) begin
        ov_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tval_r <= head.tval;
      last_r <= last_res;
      if (is_send) begin
        kind_r  <= KIND_MSG;
        dest_r  <= (idx_r == 2'd0) ? head.dest0 : head.dest1;
        mtype_r <= head.mtype;
        win_r   <= '0;
      end else begin
        kind_r  <= KIND_COMMIT;
        dest_r  <= '0;
        mtype_r <= MT_UPDATE;
        win_r   <= head.window;
      end
    end
  end

  assign count      = cnt_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = {win_r, tval_r, mtype_r, dest_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

// File: rtl/core/gvt_reduction_tree_node_unit.sv
// Path: input register, stage 2 register, window stages, group queue, then the output register.
// Throughput: one item per cycle on input while in_tready is high; one result item per
//   cycle on output while out_tready is high, so the results of an item (up to 3) leave in turn.
// Reset (rst_n low, synchronous): clears node state, queues and pipeline valids;
//   registers return to node_id 0, node_count 1, window_mult 1.0.
module gvt_reduction_tree_node_unit import gvtn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // configuration write port
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [95:0]       in_tdata,   // msg_time[47:0], local_lvt[95:48]
  input  logic [1:0]        in_tuser,   // operation[1:0]
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [103:0]      out_tdata,  // dest_node[5:0], msg_type[7:6],
                                        // out_time[55:8], window[103:56]
  output logic [0:0]        out_tuser,  // kind[0]
  output logic              out_tlast   // last result item of an input item
);

  // Configuration registers
  logic [NODE_W-1:0] node_id_r;
  logic [CNT_W-1:0]  node_count_r;
  logic [MULT_W-1:0] window_mult_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r     <= '0;
      node_count_r  <= CNT_W'(1);
      window_mult_r <= MULT_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NODE_ID:     node_id_r     <= cfg_wdata[NODE_W-1:0];
        REG_NODE_COUNT:  node_count_r  <= cfg_wdata[CNT_W-1:0];
        REG_WINDOW_MULT: window_mult_r <= cfg_wdata[MULT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Topology is a pure function of the configuration; registered every cycle.
  topo_t topo;

  gvtn_topo u_topo (
    .clk        (clk),
    .node_id    (node_id_r),
    .node_count (node_count_r),
    .topo       (topo)
  );

  // Credit scheme: the pipeline never stalls, so an item is taken only when
  // the group queue can hold it together with every item still in flight.
  logic             acc, done, push;
  logic [GQ_CW-1:0] inflight_r, q_count;
  logic [GQ_CW:0]   occ;

  assign occ       = {1'b0, inflight_r} + {1'b0, q_count};
  assign in_tready = occ < (GQ_CW + 1)'(GQ_DEPTH);
  assign acc       = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + GQ_CW'(acc) - GQ_CW'(done);
    end
  end

  // Stage 1: node state update and result list for the item
  logic s2_valid;
  grp_t s2_grp;
  cmt_t s2_cmt;

  gvtn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .op        (in_tuser),
    .msg_time  (in_tdata[47:0]),
    .local_lvt (in_tdata[95:48]),
    .topo      (topo),
    .s2_valid  (s2_valid),
    .s2_grp    (s2_grp),
    .s2_cmt    (s2_cmt)
  );

  // Stages 2 to 4: throttle window, two 16x24 partial products then add,
  // kept in order so a non-increasing commit sees the previous bound.
  grp_t push_grp;

  gvtn_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .s2_valid    (s2_valid),
    .s2_grp      (s2_grp),
    .s2_cmt      (s2_cmt),
    .window_mult (window_mult_r),
    .done        (done),
    .push        (push),
    .push_grp    (push_grp)
  );

  // Group queue and serialiser feeding the output register
  gvtn_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_grp   (push_grp),
    .count      (q_count),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: sim/tb_gvt_reduction_tree_node_unit.sv
`timescale 1ns / 1ps

module tb_gvt_reduction_tree_node_unit;
  import gvtn_pkg::*;

  // Operation code the block must ignore; the package names only the live ones
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Idle time to let the pipeline drain before touching registers
  localparam int DRAIN_CYCLES = 16;
  // Limit sized for about 130 items, each up to 3 results behind long output
  // stalls, plus sender gaps and a drain per node setting, with a wide margin.
  localparam int CYCLE_LIMIT  = 200000;

  // One item on the input channel
  typedef struct packed {
    logic [1:0]        op;
    logic [TIME_W-1:0] mtime;
    logic [TIME_W-1:0] lvt;
  } node_item_t;

  // One result item as it should appear on the output channel
  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] dest;
    logic [1:0]        mtype;
    logic [TIME_W-1:0] tval;
    logic [TIME_W-1:0] win;
    logic              last;
  } node_result_t;

  // Where this node sits in the two trees
  typedef struct {
    int n;
    int nfrom, from0, from1;
    int nto, to0, to1;
    int out0, out1;
  } node_links_t;

  // DUT ports, all known from time zero
  logic                clk;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [IDX_W-1:0]    cfg_index  = '0;
  logic [CFG_W-1:0]    cfg_wdata  = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [95:0]         in_tdata   = '0;  // msg_time[47:0], local_lvt[95:48]
  logic [1:0]          in_tuser   = '0;  // operation[1:0]
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [103:0]        out_tdata;        // dest_node[5:0], msg_type[7:6],
                                         // out_time[55:8], window[103:56]
  logic [0:0]          out_tuser;        // kind[0]
  logic                out_tlast;

  gvt_reduction_tree_node_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the node: registers and reduction state, at reset values
  // ---------------------------------------------------------------------------
  logic [NODE_W-1:0] cfg_id         = '0;
  logic [CNT_W-1:0]  cfg_count      = CNT_W'(1);
  logic [MULT_W-1:0] cfg_mult       = MULT_W'(256);
  logic [TIME_W-1:0] gvt_value      = '0;
  logic [TIME_W-1:0] fold_min       = T_ONES;
  logic              half_arrived   = 1'b0;   // shared by start and report waits
  logic [TIME_W-1:0] throttle_bound = T_INF;

  node_item_t   items_to_send[$];     // fed by the stimulus, drained by the driver
  node_result_t expected_results[$];  // oldest first
  node_result_t step_results[$];      // scratch for the item being predicted

  int mismatch_count  = 0;
  int results_seen    = 0;
  int commits_seen    = 0;
  int items_accepted  = 0;
  int settings_run    = 0;
  int planned_items   = 0;
  int cycle_count     = 0;
  logic [TIME_W-1:0] time_floor = TIME_W'(48'h1000);

  // Link derivation. Node count clamps to 1..MAX_NODES; ids at or above the
  // count go through the same formulas and destinations wrap to 6 bits.
  function automatic node_links_t derive_links();
    node_links_t l;
    int n, me, mid0, mid1, inv, ofrom, in0, in1, into, p0, p1;
    n = int'(cfg_count);
    if (n < 1) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    me = int'(cfg_id);
    l.n = n;
    mid0 = (n - 1) / 2;
    mid1 = (n % 2 == 1) ? mid0 : mid0 + 1;
    inv = n - me - 1;
    l.out0 = 2 * me + 1;
    l.out1 = l.out0 + 1;
    ofrom = (me > 0) ? (me - 1) / 2 : 0;
    in0 = 2 * me - n;
    in1 = in0 - 1;
    into = (n + me + 1) / 2;
    // smallest full subtree covering the middle decides where the trees meet
    p0 = 1;
    while (p0 < mid0 + 1) p0 = 2 * p0 + 1;
    p0 = p0 / 2 - 1;
    p1 = n - p0 - 1;
    if (p1 <= 2 * p0 + 3) begin
      mid0 = p1 - 1;
      mid1 = p0 + 1;
    end
    l.from0 = 0;
    l.from1 = 0;
    l.to0   = 0;
    l.to1   = 0;
    if (me == 0) begin
      l.nfrom = 0;
    end else if (me <= mid0) begin
      l.nfrom = 1;
      l.from0 = ofrom;
    end else if (mid1 <= in1) begin
      l.nfrom = 2;
      l.from0 = in0;
      l.from1 = in1;
    end else if (mid1 == in0) begin
      l.nfrom = 1;
      l.from0 = in0;
    end else begin
      l.nfrom = 1;
      l.from0 = inv;
    end
    if (me == n - 1) begin
      l.nto = 0;
    end else if (me >= mid1) begin
      l.nto = 1;
      l.to0 = into;
    end else if (mid0 >= l.out1) begin
      l.nto = 2;
      l.to0 = l.out0;
      l.to1 = l.out1;
    end else if (mid0 == l.out0) begin
      l.nto = 1;
      l.to0 = l.out0;
    end else begin
      l.nto = 1;
      l.to0 = inv;
    end
    return l;
  endfunction

  task automatic emit_message(input int dest, input logic [1:0] mtype,
                              input logic [TIME_W-1:0] tval);
    node_result_t r;
    r.kind  = KIND_MSG;
    r.dest  = NODE_W'(dest);
    r.mtype = mtype;
    r.tval  = tval;
    r.win   = '0;
    r.last  = 1'b0;
    step_results.push_back(r);
  endtask

  // New global value: forward down tree A, then commit locally with the throttle
  // window old + floor(mult * rise / 256) when the value rises, capped at infinity
  task automatic commit_value(input node_links_t l, input logic [TIME_W-1:0] v);
    logic [TIME_W-1:0] rise;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] inc;
    node_result_t      r;
    if (l.out0 < l.n) emit_message(l.out0, MT_UPDATE, v);
    if (l.out1 < l.n) emit_message(l.out1, MT_UPDATE, v);
    fold_min = T_ONES;
    if (v > gvt_value) begin
      rise = v - gvt_value;
      prod = PROD_W'(cfg_mult) * PROD_W'(rise);
      inc  = prod >> FRAC_W;
      if (inc > PROD_W'(T_INF - gvt_value)) throttle_bound = T_INF;
      else throttle_bound = gvt_value + inc[TIME_W-1:0];
    end
    gvt_value = v;
    r.kind  = KIND_COMMIT;
    r.dest  = '0;
    r.mtype = MT_UPDATE;
    r.tval  = v;
    r.win   = throttle_bound;
    r.last  = 1'b0;
    step_results.push_back(r);
  endtask

  // Fold a report into the running minimum; local time is taken only when
  // the shared wait bit is clear, whoever set it
  task automatic fold_report(input node_links_t l, input logic [TIME_W-1:0] lvt,
                             input logic [TIME_W-1:0] local_t);
    if (!half_arrived) fold_min = local_t;
    if (lvt < fold_min) fold_min = lvt;
    if (l.nto == 2) begin
      if (!half_arrived) begin
        half_arrived = 1'b1;
        return;
      end
      half_arrived = 1'b0;
    end
    if (l.nfrom == 2) begin
      emit_message(l.from0, MT_REPORT, fold_min);
      emit_message(l.from1, MT_REPORT, fold_min);
    end else if (l.nfrom == 1) begin
      emit_message(l.from0, MT_REPORT, fold_min);
    end else begin
      commit_value(l, fold_min);
    end
  endtask

  // Work out every result of one accepted item and queue them
  task automatic predict_node_results(input node_item_t it);
    node_links_t  l;
    node_result_t r;
    logic         go;
    step_results.delete();
    l = derive_links();
    case (it.op)
      OP_START: begin
        go = 1'b1;
        if (l.nfrom == 2) begin
          if (!half_arrived) begin
            half_arrived = 1'b1;
            go = 1'b0;
          end else begin
            half_arrived = 1'b0;
          end
        end
        if (go) begin
          if (l.nto == 2) begin
            emit_message(l.to0, MT_START, gvt_value);
            emit_message(l.to1, MT_START, gvt_value);
          end else if (l.nto == 1) begin
            emit_message(l.to0, MT_START, gvt_value);
          end else begin
            // last node of tree B starts its own report
            fold_report(l, fold_min, it.lvt);
          end
        end
      end
      OP_REPORT: fold_report(l, it.mtime, it.lvt);
      OP_UPDATE: commit_value(l, it.mtime);
      default: ;  // ignored, no result
    endcase
    if (step_results.size() != 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("t=%0t result %0d: %s got 0x%0h, expected 0x%0h",
               $time, results_seen, what, got, want);
  endtask

  // Outputs sampled at the edge, before the DUT's own updates land
  always @(posedge clk) begin : result_monitor
    node_result_t got;
    node_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind  = out_tuser[0];
      got.dest  = out_tdata[5:0];
      got.mtype = out_tdata[7:6];
      got.tval  = out_tdata[55:8];
      got.win   = out_tdata[103:56];
      got.last  = out_tlast;
      results_seen++;
      if (got.kind === KIND_COMMIT) commits_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item, time", 64'(got.tval), '0);
      end else begin
        want = expected_results.pop_front();
        if (got.kind  !== want.kind)  report_mismatch("kind",      64'(got.kind),  64'(want.kind));
        if (got.dest  !== want.dest)  report_mismatch("dest_node", 64'(got.dest),  64'(want.dest));
        if (got.mtype !== want.mtype) report_mismatch("msg_type",  64'(got.mtype), 64'(want.mtype));
        if (got.tval  !== want.tval)  report_mismatch("out_time",  64'(got.tval),  64'(want.tval));
        if (got.win   !== want.win)   report_mismatch("window",    64'(got.win),   64'(want.win));
        if (got.last  !== want.last)  report_mismatch("tlast",     64'(got.last),  64'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input driver: bursts of random length, random gaps between them.
  // Prediction happens here, on the accepting edge.
  // ---------------------------------------------------------------------------
  node_item_t drv_item = '0;
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : item_driver
    logic holding;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      holding = in_tvalid;
      if (in_tvalid && in_tready) begin
        predict_node_results(drv_item);
        items_accepted++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (items_to_send.size() != 0) begin
          drv_item = items_to_send.pop_front();
          holding  = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            // a third of bursts run straight into the next
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_tvalid <= holding;
      in_tuser  <= drv_item.op;
      in_tdata  <= {drv_item.lvt, drv_item.mtime};
    end
  end

  // Receiver: stall density changes after each random stretch, 0 % being no stall
  always @(posedge clk) begin : result_sink
    int stall_pct;
    int stretch_left;
    if (!rst_n) begin
      out_tready   <= 1'b0;
      stretch_left = 0;
      stall_pct    = 0;
    end else begin
      if (stretch_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
        stretch_left = $urandom_range(16, 96);
      end else begin
        stretch_left--;
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results still outstanding",
               cycle_count, expected_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return T_ONES;
      2:       return T_INF;
      3, 4, 5: return TIME_W'({$urandom, $urandom});
      // close to a rising floor, so commits land on sane window bounds
      default: return time_floor + TIME_W'($urandom_range(0, 1 << 20));
    endcase
  endfunction

  task automatic queue_item(input logic [1:0] op, input logic [TIME_W-1:0] mtime,
                            input logic [TIME_W-1:0] lvt);
    node_item_t it;
    it.op    = op;
    it.mtime = mtime;
    it.lvt   = lvt;
    items_to_send.push_back(it);
    if (op != OP_UNUSED) planned_items++;
  endtask

  // Mostly well-formed rounds (starts, then reports, sometimes an update)
  // with random content; the rest is single items of any operation
  task automatic queue_random_items(input int goal);
    int k;
    planned_items = 0;
    while (planned_items < goal) begin
      if ($urandom_range(0, 4) != 0) begin
        k = $urandom_range(1, 2);
        repeat (k) queue_item(OP_START, pick_time(), pick_time());
        k = $urandom_range(1, 2);
        repeat (k) queue_item(OP_REPORT, pick_time(), pick_time());
        if ($urandom_range(0, 3) == 0) queue_item(OP_UPDATE, pick_time(), pick_time());
      end else begin
        queue_item(2'($urandom_range(0, 3)), pick_time(), pick_time());
      end
    end
  endtask

  task automatic queue_directed(input int sel);
    case (sel)
      // lone root: a start reports and commits at once; update extremes,
      // an update that lowers the value, and the unused operation
      0: begin
        queue_item(OP_START,  '0,           48'h100);
        queue_item(OP_REPORT, T_ONES,       '0);
        queue_item(OP_UPDATE, T_INF,        T_ONES);
        queue_item(OP_UPDATE, T_ONES,       '0);
        queue_item(OP_UPDATE, '0,           '0);
        queue_item(OP_UNUSED, T_ONES,       T_ONES);
        queue_item(OP_REPORT, 48'h5000,     T_ONES);
      end
      // root of 64 with full multiplier: two starts out, two-report wait
      1: begin
        queue_item(OP_START,  '0,           '0);
        queue_item(OP_REPORT, 48'h1234,     48'hFFFF_0000_0000);
        queue_item(OP_REPORT, 48'h2000,     '0);
        queue_item(OP_UPDATE, 48'h8000_0000_0000, '0);
        queue_item(OP_UPDATE, T_INF,        '0);
        queue_item(OP_START,  T_ONES,       T_ONES);
      end
      // two-sender node, zero multiplier: start wait, then a report that
      // finds the wait bit left set by a start
      2: begin
        queue_item(OP_START,  '0,           '0);
        queue_item(OP_START,  '0,           '0);
        queue_item(OP_START,  '0,           '0);
        queue_item(OP_REPORT, 48'h10,       48'h20);
        queue_item(OP_UPDATE, 48'h300,      '0);
        queue_item(OP_REPORT, T_INF,        48'h7);
        queue_item(OP_UNUSED, '0,           '0);
      end
      default: ;
    endcase
  endtask

  // Nothing in flight: queue drained, all results back, pipeline flushed
  task automatic settle();
    @(negedge clk);
    while (items_to_send.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_NODE_ID:     cfg_id    = val[NODE_W-1:0];
      REG_NODE_COUNT:  cfg_count = val[CNT_W-1:0];
      REG_WINDOW_MULT: cfg_mult  = val[MULT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_setting(input int sel, input int id, input int count, input int mult);
    settle();
    write_reg(REG_NODE_ID,     CFG_W'(id));
    write_reg(REG_NODE_COUNT,  CFG_W'(count));
    write_reg(REG_WINDOW_MULT, CFG_W'(mult));
    @(posedge clk);
    cfg_we <= 1'b0;
    time_floor = time_floor + TIME_W'($urandom_range(0, 1 << 24));
    queue_directed(sel);
    queue_random_items(7);
    settings_run++;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    run_setting(0,  0,   1,   256);    // root and last node at once
    run_setting(1,  0,   64,  65535);  // root of full tree, largest multiplier
    run_setting(2,  50,  64,  0);      // two senders in tree B, zero multiplier
    run_setting(3,  63,  64,  256);    // last node of the full tree
    run_setting(4,  1,   12,  384);    // two receivers in tree A
    run_setting(5,  5,   12,  $urandom_range(0, 65535));
    run_setting(6,  40,  7,   128);    // id beyond the count
    run_setting(7,  3,   0,   512);    // count of zero acts as one
    run_setting(8,  10,  127, 1);      // count above the maximum
    run_setting(9,  $urandom_range(0, 63), $urandom_range(1, 64),
                $urandom_range(0, 65535));
    run_setting(10, 0,   2,   300);
    settle();

    $display("Sent %0d items over %0d node settings, checked %0d result items (%0d commits).",
             items_accepted, settings_run, results_seen, commits_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d field mismatches", mismatch_count);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
